// File: sv/crsm_pkg.sv
package crsm_pkg;

   localparam int ROW_COUNT_DEF   = 5;
   localparam int OUT_COUNT_DEF   = 5;
   localparam int COEFF_COUNT_DEF = 1024;
   localparam int VALUE_BITS_DEF  = 24;

   localparam int ROW_BITS   = 3;
   localparam int OUT_BITS   = 3;
   localparam int COEFF_BITS = 10;
   localparam int VAL_BITS   = 24;
   localparam int ACC_BITS   = 52;

   localparam int REQ_TDATA_BITS = 2 * VAL_BITS + COEFF_BITS + OUT_BITS + ROW_BITS;
   localparam int RSP_FIELD_BITS = 2 * ACC_BITS + COEFF_BITS + OUT_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - RSP_FIELD_BITS;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   typedef struct packed {
      logic                  valid;
      logic                  first;
      logic                  last;
      logic [COEFF_BITS-1:0] coeff;
   } stage_type;

   typedef struct packed {
      logic advance;
      logic acc_en;
      logic acc_first;
   } lane_ctl_type;

endpackage

// File: sv/crsm_sel_bank.sv
module crsm_sel_bank #(
   parameter int DEPTH     = crsm_pkg::ROW_COUNT_DEF * crsm_pkg::COEFF_COUNT_DEF,
   parameter int WIDTH     = 2 * crsm_pkg::VALUE_BITS_DEF,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/crsm_mac_lane.sv
module crsm_mac_lane #(
   parameter int VALUE_BITS = crsm_pkg::VALUE_BITS_DEF
) (
   input  logic                                 clock,
   input  crsm_pkg::lane_ctl_type               ctl,
   input  logic [2*VALUE_BITS-1:0]              sel_data,
   input  logic signed [VALUE_BITS-1:0]         d_re,
   input  logic signed [VALUE_BITS-1:0]         d_im,
   output logic signed [crsm_pkg::ACC_BITS-1:0] sum_re,
   output logic signed [crsm_pkg::ACC_BITS-1:0] sum_im
);

   localparam int AccBits  = crsm_pkg::ACC_BITS;
   localparam int ProdBits = 2 * VALUE_BITS;

   logic signed [VALUE_BITS-1:0] s_re;
   logic signed [VALUE_BITS-1:0] s_im;
   logic signed [ProdBits-1:0]   prod_rr_ff;
   logic signed [ProdBits-1:0]   prod_ii_ff;
   logic signed [ProdBits-1:0]   prod_ri_ff;
   logic signed [ProdBits-1:0]   prod_ir_ff;
   logic signed [AccBits-1:0]    diff_re_ff;
   logic signed [AccBits-1:0]    diff_im_ff;
   logic signed [AccBits-1:0]    acc_re_ff;
   logic signed [AccBits-1:0]    acc_im_ff;

   assign s_re = sel_data[VALUE_BITS-1:0];
   assign s_im = sel_data[2*VALUE_BITS-1:VALUE_BITS];

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         prod_rr_ff <= d_re * s_re;
         prod_ii_ff <= d_im * s_im;
         prod_ri_ff <= d_re * s_im;
         prod_ir_ff <= d_im * s_re;
         diff_re_ff <= AccBits'(prod_rr_ff) - AccBits'(prod_ii_ff);
         diff_im_ff <= AccBits'(prod_ri_ff) + AccBits'(prod_ir_ff);
      end
   end

   assign sum_re = (ctl.acc_first ? '0 : acc_re_ff) + diff_re_ff;
   assign sum_im = (ctl.acc_first ? '0 : acc_im_ff) + diff_im_ff;

   always_ff @(posedge clock) begin
      if (ctl.acc_en) begin
         acc_re_ff <= sum_re;
         acc_im_ff <= sum_im;
      end
   end

endmodule

// File: sv/crsm_emit.sv
module crsm_emit #(
   parameter int OUT_COUNT = crsm_pkg::OUT_COUNT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic [crsm_pkg::COEFF_BITS-1:0]       load_coeff,
   input  logic [crsm_pkg::ACC_BITS-1:0]         load_re [OUT_COUNT],
   input  logic [crsm_pkg::ACC_BITS-1:0]         load_im [OUT_COUNT],
   output logic                                  can_load,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [crsm_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int CntBits = $clog2(OUT_COUNT + 1);

   logic [CntBits-1:0]              cnt_ff;
   logic [CntBits-1:0]              cnt_in;
   logic [crsm_pkg::OUT_BITS-1:0]   idx_ff;
   logic [crsm_pkg::OUT_BITS-1:0]   idx_in;
   logic [crsm_pkg::COEFF_BITS-1:0] coeff_ff;
   logic [crsm_pkg::ACC_BITS-1:0]   re_ff [OUT_COUNT];
   logic [crsm_pkg::ACC_BITS-1:0]   im_ff [OUT_COUNT];
   logic                            transfer;

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tlast  = (cnt_ff == CntBits'(1));
   assign transfer   = rsp_tvalid && rsp_tready;
   assign can_load   = (cnt_ff == '0) || (rsp_tlast && rsp_tready);

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = CntBits'(OUT_COUNT);
         idx_in = '0;
      end else if (transfer) begin
         cnt_in = cnt_ff - CntBits'(1);
         idx_in = idx_ff + crsm_pkg::OUT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   // load the buffer, or advance it by one entry per transfer
   always_ff @(posedge clock) begin
      if (load) begin
         coeff_ff <= load_coeff;
         for (int i = 0; i < OUT_COUNT; i++) begin
            re_ff[i] <= load_re[i];
            im_ff[i] <= load_im[i];
         end
      end else if (transfer) begin
         for (int i = 0; i < OUT_COUNT - 1; i++) begin
            re_ff[i] <= re_ff[i+1];
            im_ff[i] <= im_ff[i+1];
         end
      end
   end

   assign rsp_tdata = {{crsm_pkg::RSP_PAD_BITS{1'b0}}, im_ff[0], re_ff[0], coeff_ff, idx_ff};

endmodule

// File: sv/complex_row_selector_mac.sv
// Complex row-selector multiply-accumulate.
// req channel carries two kinds of transfer, told apart by req_tuser: a load
// writes one complex selector entry (row, output, coefficient) into the
// selector memory; a data transfer brings one complex value for one row of a
// coefficient slot. Row 0 restarts the five output sums, later rows add to
// them, and the last row hands all sums to the rsp channel, one transfer per
// output, with rsp_tlast on the final output.
// A new req transfer can follow each cycle while req_tready is high. The
// selector memory is split into one bank per output, so one read per cycle
// feeds all complex multipliers at once.
// The sums of a coefficient slot are ready once its last-row data transfer
// has passed the registered memory read, then multiply, combine, accumulate.
// Sums wait in an output buffer while the next slot is accumulated. If the
// buffer still holds sums when a new last row reaches the accumulators, the
// pipeline and req_tready hold until rsp transfers free it.
// Reset clears the pipeline and the output buffer; memory and accumulators
// keep their contents and are defined by loads and row-0 transfers.
module complex_row_selector_mac #(
   parameter int ROW_COUNT   = crsm_pkg::ROW_COUNT_DEF,
   parameter int OUT_COUNT   = crsm_pkg::OUT_COUNT_DEF,
   parameter int COEFF_COUNT = crsm_pkg::COEFF_COUNT_DEF,
   parameter int VALUE_BITS  = crsm_pkg::VALUE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // row_index, out_select, coeff_index, val_re, val_im
   input  logic [crsm_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // req_type
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_index, coeff_out, res_re, res_im, zero fill
   output logic [crsm_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int Depth    = ROW_COUNT * COEFF_COUNT;
   localparam int AddrBits = $clog2(Depth);
   localparam int SelBits  = 2 * VALUE_BITS;
   localparam int RowBits  = crsm_pkg::ROW_BITS;
   localparam int OutBits  = crsm_pkg::OUT_BITS;
   localparam int CoefBits = crsm_pkg::COEFF_BITS;
   localparam int ValBits  = crsm_pkg::VAL_BITS;

   logic [RowBits-1:0]  req_row;
   logic [OutBits-1:0]  req_out;
   logic [CoefBits-1:0] req_coeff;
   logic [ValBits-1:0]  req_val_re;
   logic [ValBits-1:0]  req_val_im;

   logic                row_ok;
   logic                out_ok;
   logic                coeff_ok;
   logic                advance;
   logic                accept;
   logic                load_en;
   logic                data_en;
   logic                can_load;
   logic [AddrBits-1:0] sel_addr;
   logic [SelBits-1:0]  sel_wdata;

   crsm_pkg::stage_type    s1_ff, s1_in, s2_ff, s3_ff;
   crsm_pkg::lane_ctl_type lane_ctl;

   logic signed [VALUE_BITS-1:0] d_re_ff;
   logic signed [VALUE_BITS-1:0] d_im_ff;

   logic [SelBits-1:0]            sel_rdata [OUT_COUNT];
   logic [crsm_pkg::ACC_BITS-1:0] sum_re    [OUT_COUNT];
   logic [crsm_pkg::ACC_BITS-1:0] sum_im    [OUT_COUNT];

   assign req_row    = req_tdata[RowBits-1:0];
   assign req_out    = req_tdata[RowBits+OutBits-1:RowBits];
   assign req_coeff  = req_tdata[RowBits+OutBits+CoefBits-1:RowBits+OutBits];
   assign req_val_re = req_tdata[RowBits+OutBits+CoefBits+ValBits-1:RowBits+OutBits+CoefBits];
   assign req_val_im = req_tdata[crsm_pkg::REQ_TDATA_BITS-1:RowBits+OutBits+CoefBits+ValBits];

   assign row_ok   = 32'(req_row) < ROW_COUNT;
   assign out_ok   = 32'(req_out) < OUT_COUNT;
   assign coeff_ok = 32'(req_coeff) < COEFF_COUNT;

   // hold everything while a finished slot waits for the output buffer
   assign advance    = !(s3_ff.valid && s3_ff.last && !can_load);
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   assign load_en = accept && (req_tuser[0] == crsm_pkg::REQ_LOAD) && row_ok && out_ok
                    && coeff_ok;
   assign data_en = accept && (req_tuser[0] == crsm_pkg::REQ_DATA) && row_ok && coeff_ok;

   assign sel_addr  = AddrBits'(32'(req_row) * COEFF_COUNT + 32'(req_coeff));
   assign sel_wdata = {VALUE_BITS'($signed(req_val_im)), VALUE_BITS'($signed(req_val_re))};

   always_comb begin
      s1_in.valid = data_en;
      s1_in.first = (req_row == '0);
      s1_in.last  = (32'(req_row) == ROW_COUNT - 1);
      s1_in.coeff = req_coeff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (data_en) begin
         d_re_ff <= VALUE_BITS'($signed(req_val_re));
         d_im_ff <= VALUE_BITS'($signed(req_val_im));
      end
   end

   always_comb begin
      lane_ctl.advance   = advance;
      lane_ctl.acc_en    = advance && s3_ff.valid;
      lane_ctl.acc_first = s3_ff.first;
   end

   for (genvar k = 0; k < OUT_COUNT; k++) begin : g_lane
      crsm_sel_bank #(
         .DEPTH     (Depth),
         .WIDTH     (SelBits),
         .ADDR_BITS (AddrBits)
      ) u_bank (
         .clock   (clock),
         .wr_en   (load_en && (32'(req_out) == k)),
         .wr_addr (sel_addr),
         .wr_data (sel_wdata),
         .rd_en   (data_en),
         .rd_addr (sel_addr),
         .rd_data (sel_rdata[k])
      );

      crsm_mac_lane #(
         .VALUE_BITS (VALUE_BITS)
      ) u_lane (
         .clock    (clock),
         .ctl      (lane_ctl),
         .sel_data (sel_rdata[k]),
         .d_re     (d_re_ff),
         .d_im     (d_im_ff),
         .sum_re   (sum_re[k]),
         .sum_im   (sum_im[k])
      );
   end

   crsm_emit #(
      .OUT_COUNT (OUT_COUNT)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && s3_ff.valid && s3_ff.last),
      .load_coeff (s3_ff.coeff),
      .load_re    (sum_re),
      .load_im    (sum_im),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: bench/tb_complex_row_selector_mac.sv
`timescale 1ns / 1ps

module tb_complex_row_selector_mac;

   localparam int NROW   = crsm_pkg::ROW_COUNT_DEF;
   localparam int NOUT   = crsm_pkg::OUT_COUNT_DEF;
   localparam int NCOEFF = crsm_pkg::COEFF_COUNT_DEF;
   localparam int RANDOM_ITEMS = 420;

   localparam logic [crsm_pkg::VAL_BITS-1:0] VMAX  = 24'h7fffff;
   localparam logic [crsm_pkg::VAL_BITS-1:0] VMIN  = 24'h800000;
   localparam logic [crsm_pkg::VAL_BITS-1:0] VNEG1 = 24'hffffff;
   localparam logic [crsm_pkg::VAL_BITS-1:0] VONE  = 24'h000001;
   localparam logic [crsm_pkg::VAL_BITS-1:0] VZERO = 24'h000000;
   localparam logic [crsm_pkg::COEFF_BITS-1:0] TOP_SLOT = 10'h3ff;

   typedef struct packed {
      logic                            kind;
      logic [crsm_pkg::ROW_BITS-1:0]   row;
      logic [crsm_pkg::OUT_BITS-1:0]   sel;
      logic [crsm_pkg::COEFF_BITS-1:0] coeff;
      logic [crsm_pkg::VAL_BITS-1:0]   re;
      logic [crsm_pkg::VAL_BITS-1:0]   im;
   } mac_req_type;

   typedef struct packed {
      mac_req_type req;
      logic        zero_sums;
   } plan_row_type;

   typedef struct packed {
      logic [crsm_pkg::OUT_BITS-1:0]   out_idx;
      logic [crsm_pkg::COEFF_BITS-1:0] coeff;
      logic [crsm_pkg::ACC_BITS-1:0]   re;
      logic [crsm_pkg::ACC_BITS-1:0]   im;
      logic                            last;
   } mac_sum_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   // row_index, out_select, coeff_index, val_re, val_im
   logic [crsm_pkg::REQ_TDATA_BITS-1:0] req_tdata = '0;
   // req_type
   logic [0:0]                          req_tuser = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // out_index, coeff_out, res_re, res_im, zero fill
   logic [crsm_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                                rsp_tlast;

   complex_row_selector_mac dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   logic [2*crsm_pkg::VAL_BITS-1:0] sel_mem [0:NROW*NOUT*NCOEFF-1];
   logic [crsm_pkg::ACC_BITS-1:0]   acc_re [0:NOUT-1];
   logic [crsm_pkg::ACC_BITS-1:0]   acc_im [0:NOUT-1];
   mac_sum_type                     fresh_sums [$];
   mac_sum_type                     sum_fifo [$];
   bit                              slot_full [0:NCOEFF-1];
   int                              full_slots [$];
   int                              errors = 0;
   int                              burst_left = 0;
   int                              issued = 0;

   function automatic int sel_index(int row, int col, int coeff);
      return (row * NOUT + col) * NCOEFF + coeff;
   endfunction

   function automatic bit req_ignored(mac_req_type it);
      return it.row >= NROW || (it.kind == crsm_pkg::REQ_LOAD && it.sel >= NOUT);
   endfunction

   function automatic void fold_req(mac_req_type it);
      longint d_re, d_im, s_re, s_im, p_re, p_im;
      logic [2*crsm_pkg::VAL_BITS-1:0] entry;
      fresh_sums.delete();
      if (req_ignored(it)) return;
      if (it.kind == crsm_pkg::REQ_LOAD) begin
         sel_mem[sel_index(int'(it.row), int'(it.sel), int'(it.coeff))] = {it.im, it.re};
         return;
      end
      d_re = longint'($signed(it.re));
      d_im = longint'($signed(it.im));
      for (int k = 0; k < NOUT; k++) begin
         entry = sel_mem[sel_index(int'(it.row), k, int'(it.coeff))];
         s_re = longint'($signed(entry[crsm_pkg::VAL_BITS-1:0]));
         s_im = longint'($signed(entry[2*crsm_pkg::VAL_BITS-1:crsm_pkg::VAL_BITS]));
         p_re = d_re * s_re - d_im * s_im;
         p_im = d_re * s_im + d_im * s_re;
         if (it.row == 0) begin
            acc_re[k] = p_re[crsm_pkg::ACC_BITS-1:0];
            acc_im[k] = p_im[crsm_pkg::ACC_BITS-1:0];
         end else begin
            acc_re[k] = acc_re[k] + p_re[crsm_pkg::ACC_BITS-1:0];
            acc_im[k] = acc_im[k] + p_im[crsm_pkg::ACC_BITS-1:0];
         end
      end
      if (it.row == NROW - 1)
         for (int k = 0; k < NOUT; k++)
            fresh_sums.push_back(mac_sum_type'{crsm_pkg::OUT_BITS'(k), it.coeff, acc_re[k],
                                               acc_im[k], k == NOUT - 1});
   endfunction

   function automatic mac_req_type make_req(logic kind, int row, int sel, int coeff,
                                            logic [crsm_pkg::VAL_BITS-1:0] re,
                                            logic [crsm_pkg::VAL_BITS-1:0] im);
      mac_req_type it;
      it.kind  = kind;
      it.row   = crsm_pkg::ROW_BITS'(row);
      it.sel   = crsm_pkg::OUT_BITS'(sel);
      it.coeff = crsm_pkg::COEFF_BITS'(coeff);
      it.re    = re;
      it.im    = im;
      return it;
   endfunction

   function automatic plan_row_type plan_row(logic kind, int row, int sel, int coeff,
                                             logic [crsm_pkg::VAL_BITS-1:0] re,
                                             logic [crsm_pkg::VAL_BITS-1:0] im,
                                             bit zero_sums);
      plan_row_type p;
      p.req       = make_req(kind, row, sel, coeff, re, im);
      p.zero_sums = zero_sums;
      return p;
   endfunction

   function automatic logic [crsm_pkg::VAL_BITS-1:0] rand_val();
      case ($urandom_range(0, 9))
         0: return VMAX;
         1: return VMIN;
         2: return VNEG1;
         3: return VZERO;
         default: return crsm_pkg::VAL_BITS'($urandom);
      endcase
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic send_req(mac_req_type it, bit zero_sums);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      fold_req(it);
      if (zero_sums) begin
         fresh_sums.delete();
         for (int k = 0; k < NOUT; k++)
            fresh_sums.push_back(mac_sum_type'{crsm_pkg::OUT_BITS'(k), it.coeff, '0, '0,
                                               k == NOUT - 1});
      end
      foreach (fresh_sums[k]) sum_fifo.push_back(fresh_sums[k]);
      issued++;
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {it.im, it.re, it.coeff, it.sel, it.row};
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic load_slot(int coeff);
      for (int r = 0; r < NROW; r++)
         for (int o = 0; o < NOUT; o++)
            send_req(make_req(crsm_pkg::REQ_LOAD, r, o, coeff, rand_val(), rand_val()), 1'b0);
      if (!slot_full[coeff]) begin
         slot_full[coeff] = 1'b1;
         full_slots.push_back(coeff);
      end
   endtask

   task automatic run_random();
      int pick, coeff, n;
      while (issued < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (full_slots.size() == 0 || pick < 12) begin
            load_slot($urandom_range(0, NCOEFF - 1));
         end else if (pick < 70) begin
            coeff = full_slots[$urandom_range(0, full_slots.size() - 1)];
            for (int r = 0; r < NROW; r++)
               send_req(make_req(crsm_pkg::REQ_DATA, r, $urandom_range(0, 7), coeff,
                                 rand_val(), rand_val()), 1'b0);
         end else if (pick < 84) begin
            coeff = full_slots[$urandom_range(0, full_slots.size() - 1)];
            send_req(make_req(crsm_pkg::REQ_LOAD, $urandom_range(0, NROW - 1),
                              $urandom_range(0, NOUT - 1), coeff, rand_val(), rand_val()), 1'b0);
         end else if (pick < 93) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               coeff = full_slots[$urandom_range(0, full_slots.size() - 1)];
               send_req(make_req(crsm_pkg::REQ_DATA, $urandom_range(0, NROW - 1),
                                 $urandom_range(0, 7), coeff, rand_val(), rand_val()), 1'b0);
            end
         end else if (pick < 97) begin
            send_req(make_req(1'($urandom_range(0, 1)), $urandom_range(NROW, 7),
                              $urandom_range(0, 7), $urandom_range(0, NCOEFF - 1),
                              rand_val(), rand_val()), 1'b0);
         end else begin
            send_req(make_req(crsm_pkg::REQ_LOAD, $urandom_range(0, NROW - 1),
                              $urandom_range(NOUT, 7), $urandom_range(0, NCOEFF - 1),
                              rand_val(), rand_val()), 1'b0);
         end
      end
   endtask

   int stall_left = 0;
   int stall_mode = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_left[2:0] == 3'd0);
      endcase
   end

   always @(posedge clock) begin
      mac_sum_type got, want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.out_idx = rsp_tdata[crsm_pkg::OUT_BITS-1:0];
         got.coeff   = rsp_tdata[crsm_pkg::OUT_BITS +: crsm_pkg::COEFF_BITS];
         got.re      = rsp_tdata[crsm_pkg::OUT_BITS+crsm_pkg::COEFF_BITS +: crsm_pkg::ACC_BITS];
         got.im      = rsp_tdata[crsm_pkg::OUT_BITS+crsm_pkg::COEFF_BITS+crsm_pkg::ACC_BITS
                                 +: crsm_pkg::ACC_BITS];
         got.last    = rsp_tlast;
         if (sum_fifo.size() == 0) begin
            $display("%0t: unexpected transfer expected none actual %h", $time, got);
            errors++;
         end else begin
            want = sum_fifo.pop_front();
            check_field("out_index", 64'(want.out_idx), 64'(got.out_idx));
            check_field("coeff_out", 64'(want.coeff), 64'(got.coeff));
            check_field("res_re", 64'(want.re), 64'(got.re));
            check_field("res_im", 64'(want.im), 64'(got.im));
            check_field("last", 64'(want.last), 64'(got.last));
            check_field("zero_fill", 64'(0),
                        64'(rsp_tdata[crsm_pkg::RSP_TDATA_BITS-1:crsm_pkg::RSP_FIELD_BITS]));
         end
      end
   end

   initial begin
      plan_row_type plan [$];
      plan.push_back(plan_row(crsm_pkg::REQ_LOAD, 0, 0, TOP_SLOT, VMAX,  VMAX,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_LOAD, 0, 1, TOP_SLOT, VMIN,  VMIN,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_LOAD, 0, 2, TOP_SLOT, VMAX,  VMIN,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_LOAD, 0, 3, TOP_SLOT, VMIN,  VMAX,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_LOAD, 0, 4, TOP_SLOT, VNEG1, VONE,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_LOAD, 4, 0, TOP_SLOT, VMIN,  VMAX,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_LOAD, 4, 1, TOP_SLOT, VMAX,  VMIN,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_LOAD, 4, 2, TOP_SLOT, VMAX,  VMAX,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_LOAD, 4, 3, TOP_SLOT, VMIN,  VMIN,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_LOAD, 4, 4, TOP_SLOT, VZERO, VNEG1, 1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_LOAD, 7, 2, TOP_SLOT, VNEG1, VNEG1, 1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_LOAD, 4, 7, TOP_SLOT, VNEG1, VNEG1, 1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_LOAD, 5, 5, 0,        VNEG1, VNEG1, 1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_DATA, 0, 0, TOP_SLOT, VZERO, VZERO, 1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_DATA, 4, 0, TOP_SLOT, VZERO, VZERO, 1'b1));
      plan.push_back(plan_row(crsm_pkg::REQ_DATA, 0, 7, TOP_SLOT, VMAX,  VMAX,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_DATA, 4, 0, TOP_SLOT, VMIN,  VMIN,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_DATA, 6, 0, TOP_SLOT, VMAX,  VMIN,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_DATA, 0, 3, TOP_SLOT, VMIN,  VMAX,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_DATA, 4, 0, TOP_SLOT, VMAX,  VMIN,  1'b0));
      plan.push_back(plan_row(crsm_pkg::REQ_DATA, 4, 0, TOP_SLOT, VNEG1, VNEG1, 1'b0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_req(plan[i].req, plan[i].zero_sums);
      issued = 0;
      run_random();
      req_tvalid <= 1'b0;

      while (sum_fifo.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
